// ----- hdl/mws_pkg.sv -----
// Shared types and constants of the magnifier window sampler.
`default_nettype none

package mws_pkg;

    localparam int COORD_W = 16;
    localparam int EXT_W   = 16;
    localparam int RAS_W   = 9;
    localparam int PIX_W   = 32;
    localparam int WIN_W   = 3;
    localparam int PADDR_W = 5;
    localparam int PDATA_W = 32;

    localparam logic [2:0] REG_BOUNDS_LEFT   = 3'd0;
    localparam logic [2:0] REG_BOUNDS_TOP    = 3'd1;
    localparam logic [2:0] REG_BOUNDS_WIDTH  = 3'd2;
    localparam logic [2:0] REG_BOUNDS_HEIGHT = 3'd3;
    localparam logic [2:0] REG_RASTER_WIDTH  = 3'd4;
    localparam logic [2:0] REG_RASTER_HEIGHT = 3'd5;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef struct packed {
        logic in_ready;
        logic sel_x;
        logic off_en;
        logic mul_en;
        logic div_start;
        logic store_q;
        logic col_clr;
        logic col_inc;
        logic row_clr;
        logic row_inc;
        logic mem_rd;
        logic out_pixel;
        logic out_empty;
    } mws_cmd_t;

    typedef struct packed {
        logic empty;
        logic div_done;
        logic col_last;
        logic row_last;
        logic row_zero;
        logic out_free;
    } mws_status_t;

endpackage : mws_pkg

`default_nettype wire

// ----- hdl/mws_ram.sv -----
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none

module mws_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 65536
) (
    input  wire logic                                       clk,
    input  wire logic                                       we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                           wdata,
    input  wire logic                                       re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                           rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule : mws_ram

`default_nettype wire

// ----- hdl/mws_div.sv -----
// Iterative restoring divider that produces one quotient bit per cycle.
`default_nettype none

module mws_div #(
    parameter int NUM_W = 26,
    parameter int DEN_W = 17,
    parameter int QW    = 9
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [NUM_W-1:0] num,
    input  wire logic [DEN_W-1:0] den,
    output logic                  done,
    output logic      [QW-1:0]    quot
);

    localparam int CNT_W = $clog2(QW + 1);

    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [QW-1:0]    shq_reg, shq_next;
    logic [DEN_W-1:0] den_reg;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [DEN_W:0]   trial;
    logic             ge;
    logic [QW:0]      shq_wide;

    always_comb
    begin
        trial    = {rem_reg, shq_reg[QW-1]};
        ge       = (trial >= {1'b0, den_reg});
        shq_wide = {shq_reg, ge};
        rem_next = ge ? DEN_W'(trial - {1'b0, den_reg}) : trial[DEN_W-1:0];
        shq_next = shq_wide[QW-1:0];
        cnt_next = cnt_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (start)
        begin
            cnt_reg <= CNT_W'(QW);
        end
        else if (cnt_reg != '0)
        begin
            cnt_reg <= cnt_next;
        end
    end

    // The top bits of the numerator are already below the divisor, since the
    // quotient is known to fit in QW bits.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= num[NUM_W-1:QW];
            shq_reg <= num[QW-1:0];
            den_reg <= den;
        end
        else if (cnt_reg != '0)
        begin
            rem_reg <= rem_next;
            shq_reg <= shq_next;
        end
    end

    assign done = (cnt_reg == '0);
    assign quot = shq_reg;

endmodule : mws_div

`default_nettype wire

// ----- hdl/mws_ctrl.sv -----
// Controller state machine that sequences loads, bounds checks and window scans.
`default_nettype none

module mws_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    input  wire logic                 op,
    input  wire mws_pkg::mws_status_t status,
    output mws_pkg::mws_cmd_t         cmd
);

    import mws_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_EMPTY,
        ST_OFF,
        ST_MUL,
        ST_DIVGO,
        ST_DIVWAIT,
        ST_READ,
        ST_EMIT
    } state_t;

    state_t state_reg, state_next;
    logic   axis_x_reg, axis_x_next;

    always_comb
    begin
        state_next  = state_reg;
        axis_x_next = axis_x_reg;
        cmd         = '0;
        cmd.sel_x   = axis_x_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.in_ready = 1'b1;
                if (in_valid && (op == OP_QUERY))
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (status.empty)
                begin
                    state_next = ST_EMPTY;
                end
                else
                begin
                    axis_x_next = 1'b0;
                    state_next  = ST_OFF;
                end
            end
            ST_EMPTY:
            begin
                if (status.out_free)
                begin
                    cmd.out_empty = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            ST_OFF:
            begin
                cmd.off_en = 1'b1;
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                cmd.mul_en = 1'b1;
                state_next = ST_DIVGO;
            end
            ST_DIVGO:
            begin
                cmd.div_start = 1'b1;
                state_next    = ST_DIVWAIT;
            end
            ST_DIVWAIT:
            begin
                if (status.div_done)
                begin
                    cmd.store_q = 1'b1;
                    if (!axis_x_reg)
                    begin
                        cmd.col_clr = 1'b1;
                        // Column mappings are worked out once, during the first row.
                        if (status.row_zero)
                        begin
                            axis_x_next = 1'b1;
                            state_next  = ST_OFF;
                        end
                        else
                        begin
                            state_next = ST_READ;
                        end
                    end
                    else if (status.col_last)
                    begin
                        cmd.col_clr = 1'b1;
                        state_next  = ST_READ;
                    end
                    else
                    begin
                        cmd.col_inc = 1'b1;
                        state_next  = ST_OFF;
                    end
                end
            end
            ST_READ:
            begin
                cmd.mem_rd = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.out_pixel = 1'b1;
                    if (!status.col_last)
                    begin
                        cmd.col_inc = 1'b1;
                        state_next  = ST_READ;
                    end
                    else if (!status.row_last)
                    begin
                        cmd.row_inc = 1'b1;
                        cmd.col_clr = 1'b1;
                        axis_x_next = 1'b0;
                        state_next  = ST_OFF;
                    end
                    else
                    begin
                        cmd.row_clr = 1'b1;
                        cmd.col_clr = 1'b1;
                        state_next  = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            axis_x_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            axis_x_reg <= axis_x_next;
        end
    end

endmodule : mws_ctrl

`default_nettype wire

// ----- hdl/mws_dp.sv -----
// Datapath: pixel store, coordinate mapping, window counters and result register.
`default_nettype none

module mws_dp #(
    parameter int PREVIEW_SIZE      = 7,
    parameter int RASTER_MAX_WIDTH  = 256,
    parameter int RASTER_MAX_HEIGHT = 256
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire mws_pkg::mws_cmd_t                  cmd,
    output mws_pkg::mws_status_t                    status,
    input  wire logic                               in_valid,
    input  wire logic                               op,
    input  wire logic signed [mws_pkg::COORD_W-1:0] point_x,
    input  wire logic signed [mws_pkg::COORD_W-1:0] point_y,
    input  wire logic        [mws_pkg::PIX_W-1:0]   pixel_in,
    input  wire logic signed [mws_pkg::COORD_W-1:0] bounds_left,
    input  wire logic signed [mws_pkg::COORD_W-1:0] bounds_top,
    input  wire logic        [mws_pkg::EXT_W-1:0]   bounds_width,
    input  wire logic        [mws_pkg::EXT_W-1:0]   bounds_height,
    input  wire logic        [mws_pkg::RAS_W-1:0]   raster_width,
    input  wire logic        [mws_pkg::RAS_W-1:0]   raster_height,
    input  wire logic                               out_stall,
    output logic                                    out_valid,
    output logic                                    preview_valid,
    output logic             [mws_pkg::PIX_W-1:0]   pixel_out,
    output logic             [mws_pkg::WIN_W-1:0]   window_x,
    output logic             [mws_pkg::WIN_W-1:0]   window_y,
    output logic                                    last
);

    import mws_pkg::*;

    localparam int RADIUS = PREVIEW_SIZE / 2;
    localparam int RMAX   = (RASTER_MAX_WIDTH > RASTER_MAX_HEIGHT) ?
                            RASTER_MAX_WIDTH : RASTER_MAX_HEIGHT;
    localparam int RW     = $clog2(RMAX + 1);
    localparam int CW     = (RASTER_MAX_WIDTH > 1) ? $clog2(RASTER_MAX_WIDTH) : 1;
    localparam int RHW    = (RASTER_MAX_HEIGHT > 1) ? $clog2(RASTER_MAX_HEIGHT) : 1;
    localparam int DEPTH  = RASTER_MAX_WIDTH * RASTER_MAX_HEIGHT;
    localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int DEN_W  = EXT_W + 1;
    localparam int NUM_W  = EXT_W + 1 + RW;
    localparam int D_W    = COORD_W + 4;
    localparam int B_W    = COORD_W + 2;

    // Query point and window counters.
    logic signed [COORD_W-1:0] qx_reg, qy_reg;
    logic [WIN_W-1:0]          row_reg, col_reg;

    // Mapping pipeline.
    logic [EXT_W-1:0]  off_reg;
    logic [NUM_W-1:0]  prod_reg;
    logic [RHW-1:0]    ry_reg;
    logic [CW-1:0]     col_map [2**WIN_W];

    // Result register.
    logic              out_valid_reg;
    logic              pv_reg;
    logic [PIX_W-1:0]  pix_reg;
    logic [WIN_W-1:0]  wx_reg, wy_reg;
    logic              last_reg;

    logic              accept;
    logic              q_empty;
    logic [RW-1:0]     rw_sat, rh_sat;
    logic signed [B_W-1:0] left_e, top_e, right_e, bottom_e, qx_e, qy_e;

    logic signed [COORD_W-1:0] m_base, m_start;
    logic [EXT_W-1:0]          m_ext;
    logic [RW-1:0]             m_rext;
    logic [WIN_W-1:0]          m_idx;
    logic signed [D_W-1:0]     m_d;
    logic [EXT_W-1:0]          m_off;

    logic              div_done;
    logic [RW-1:0]     quot;
    logic              we;
    logic [AW-1:0]     waddr, raddr;
    logic [PIX_W-1:0]  rdata;

    assign accept = in_valid && cmd.in_ready;

    // Raster extents above the store size saturate to the store size.
    always_comb
    begin
        rw_sat = (32'(raster_width) > RASTER_MAX_WIDTH) ?
                 RW'(RASTER_MAX_WIDTH) : RW'(raster_width);
        rh_sat = (32'(raster_height) > RASTER_MAX_HEIGHT) ?
                 RW'(RASTER_MAX_HEIGHT) : RW'(raster_height);
    end

    always_comb
    begin
        left_e   = B_W'(bounds_left);
        top_e    = B_W'(bounds_top);
        right_e  = left_e + signed'({2'b00, bounds_width}) - B_W'(1);
        bottom_e = top_e + signed'({2'b00, bounds_height}) - B_W'(1);
        qx_e     = B_W'(qx_reg);
        qy_e     = B_W'(qy_reg);
        q_empty  = (rw_sat == '0) || (rh_sat == '0) ||
                   (bounds_width == '0) || (bounds_height == '0) ||
                   (qx_e < left_e) || (qx_e > right_e) ||
                   (qy_e < top_e) || (qy_e > bottom_e);
    end

    // Offset of the window coordinate from the bounds edge, clamped to the bounds.
    always_comb
    begin
        m_base  = cmd.sel_x ? qx_reg : qy_reg;
        m_start = cmd.sel_x ? bounds_left : bounds_top;
        m_ext   = cmd.sel_x ? bounds_width : bounds_height;
        m_rext  = cmd.sel_x ? rw_sat : rh_sat;
        m_idx   = cmd.sel_x ? col_reg : row_reg;
        m_d     = D_W'(m_base) - D_W'(m_start) + signed'(D_W'(m_idx)) - D_W'(RADIUS);
        if (m_d < 0)
        begin
            m_off = '0;
        end
        else if (m_d >= signed'(D_W'(m_ext)))
        begin
            m_off = m_ext - EXT_W'(1);
        end
        else
        begin
            m_off = m_d[EXT_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            qx_reg <= point_x;
            qy_reg <= point_y;
        end
        if (cmd.off_en)
        begin
            off_reg <= m_off;
        end
        if (cmd.mul_en)
        begin
            prod_reg <= NUM_W'({off_reg, 1'b1}) * NUM_W'(m_rext);
        end
        if (cmd.store_q)
        begin
            if (cmd.sel_x)
            begin
                col_map[col_reg] <= quot[CW-1:0];
            end
            else
            begin
                ry_reg <= quot[RHW-1:0];
            end
        end
    end

    mws_div #(
        .NUM_W (NUM_W),
        .DEN_W (DEN_W),
        .QW    (RW)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   (prod_reg),
        .den   ({m_ext, 1'b0}),
        .done  (div_done),
        .quot  (quot)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg <= '0;
            col_reg <= '0;
        end
        else
        begin
            if (cmd.row_clr)
            begin
                row_reg <= '0;
            end
            else if (cmd.row_inc)
            begin
                row_reg <= row_reg + WIN_W'(1);
            end
            if (cmd.col_clr)
            begin
                col_reg <= '0;
            end
            else if (cmd.col_inc)
            begin
                col_reg <= col_reg + WIN_W'(1);
            end
        end
    end

    // Loads outside the store are dropped.
    always_comb
    begin
        we    = accept && (op == OP_LOAD) &&
                !point_x[COORD_W-1] && (32'(point_x) < RASTER_MAX_WIDTH) &&
                !point_y[COORD_W-1] && (32'(point_y) < RASTER_MAX_HEIGHT);
        waddr = AW'(32'(point_y[RHW-1:0]) * RASTER_MAX_WIDTH + 32'(point_x[CW-1:0]));
        raddr = AW'(32'(ry_reg) * RASTER_MAX_WIDTH + 32'(col_map[col_reg]));
    end

    mws_ram #(
        .WIDTH (PIX_W),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (pixel_in),
        .re    (cmd.mem_rd),
        .raddr (raddr),
        .rdata (rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_pixel || cmd.out_empty)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_pixel)
        begin
            pv_reg   <= 1'b1;
            pix_reg  <= rdata;
            wx_reg   <= col_reg;
            wy_reg   <= row_reg;
            last_reg <= status.row_last && status.col_last;
        end
        else if (cmd.out_empty)
        begin
            pv_reg   <= 1'b0;
            pix_reg  <= '0;
            wx_reg   <= '0;
            wy_reg   <= '0;
            last_reg <= 1'b1;
        end
    end

    always_comb
    begin
        status.empty    = q_empty;
        status.div_done = div_done;
        status.col_last = (32'(col_reg) == PREVIEW_SIZE - 1);
        status.row_last = (32'(row_reg) == PREVIEW_SIZE - 1);
        status.row_zero = (row_reg == '0);
        status.out_free = !out_valid_reg || !out_stall;
    end

    assign out_valid     = out_valid_reg;
    assign preview_valid = pv_reg;
    assign pixel_out     = pix_reg;
    assign window_x      = wx_reg;
    assign window_y      = wy_reg;
    assign last          = last_reg;

endmodule : mws_dp

`default_nettype wire

// ----- hdl/magnifier_window_sampler_unit.sv -----
// Magnifier window sampler: a loaded raster sampled into a square preview window.
//
// Input channel (in_valid / in_stall): op 0 stores pixel_in at column point_x,
// row point_y of the pixel store; coordinates outside the store are dropped.
// A load gives no result. op 1 queries the preview at the
// physical point (point_x, point_y).
// Output channel (out_valid / out_stall): a query outside the bounds, or with an
// empty raster or empty bounds, gives one beat with preview_valid low. Otherwise
// PREVIEW_SIZE*PREVIEW_SIZE beats come row by row, last marking the final one.
// Each mapped coordinate runs through one shared restoring divider, one quotient
// bit per cycle, for a quotient of RW = clog2(max raster size + 1) bits. Each
// beat needs one store read.
// A stalled receiver holds the current beat; the block waits on it and then
// resumes. The next item is taken while the final beat still waits.
// Configuration goes through the APB port; the user must write it only while the block
// idles, which the block does not enforce. Reset clears the configuration registers and
// the sequencer; the pixel store is undefined until loaded.
`default_nettype none

module magnifier_window_sampler_unit #(
    parameter int PREVIEW_SIZE      = 7,
    parameter int RASTER_MAX_WIDTH  = 256,
    parameter int RASTER_MAX_HEIGHT = 256
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic        [mws_pkg::PADDR_W-1:0] paddr,
    input  wire logic        [mws_pkg::PDATA_W-1:0] pwdata,
    output logic             [mws_pkg::PDATA_W-1:0] prdata,
    output logic                                    pready,
    input  wire logic                               in_valid,
    output logic                                    in_stall,
    input  wire logic                               op,
    input  wire logic signed [mws_pkg::COORD_W-1:0] point_x,
    input  wire logic signed [mws_pkg::COORD_W-1:0] point_y,
    input  wire logic        [mws_pkg::PIX_W-1:0]   pixel_in,
    output logic                                    out_valid,
    input  wire logic                               out_stall,
    output logic                                    preview_valid,
    output logic             [mws_pkg::PIX_W-1:0]   pixel_out,
    output logic             [mws_pkg::WIN_W-1:0]   window_x,
    output logic             [mws_pkg::WIN_W-1:0]   window_y,
    output logic                                    last
);

    import mws_pkg::*;

    logic signed [COORD_W-1:0] bounds_left_reg, bounds_top_reg;
    logic [EXT_W-1:0]          bounds_width_reg, bounds_height_reg;
    logic [RAS_W-1:0]          raster_width_reg, raster_height_reg;
    logic [2:0]                reg_index;
    logic                      cfg_write;
    mws_cmd_t                  cmd;
    mws_status_t               status;

    assign pready    = 1'b1;
    assign reg_index = paddr[PADDR_W-1:2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bounds_left_reg   <= '0;
            bounds_top_reg    <= '0;
            bounds_width_reg  <= '0;
            bounds_height_reg <= '0;
            raster_width_reg  <= '0;
            raster_height_reg <= '0;
        end
        else if (cfg_write)
        begin
            unique case (reg_index)
                REG_BOUNDS_LEFT:   bounds_left_reg   <= pwdata[COORD_W-1:0];
                REG_BOUNDS_TOP:    bounds_top_reg    <= pwdata[COORD_W-1:0];
                REG_BOUNDS_WIDTH:  bounds_width_reg  <= pwdata[EXT_W-1:0];
                REG_BOUNDS_HEIGHT: bounds_height_reg <= pwdata[EXT_W-1:0];
                REG_RASTER_WIDTH:  raster_width_reg  <= pwdata[RAS_W-1:0];
                REG_RASTER_HEIGHT: raster_height_reg <= pwdata[RAS_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_index)
            REG_BOUNDS_LEFT:   prdata = PDATA_W'(unsigned'(bounds_left_reg));
            REG_BOUNDS_TOP:    prdata = PDATA_W'(unsigned'(bounds_top_reg));
            REG_BOUNDS_WIDTH:  prdata = PDATA_W'(bounds_width_reg);
            REG_BOUNDS_HEIGHT: prdata = PDATA_W'(bounds_height_reg);
            REG_RASTER_WIDTH:  prdata = PDATA_W'(raster_width_reg);
            REG_RASTER_HEIGHT: prdata = PDATA_W'(raster_height_reg);
            default:           prdata = '0;
        endcase
    end

    assign in_stall = !cmd.in_ready;

    mws_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .op       (op),
        .status   (status),
        .cmd      (cmd)
    );

    mws_dp #(
        .PREVIEW_SIZE      (PREVIEW_SIZE),
        .RASTER_MAX_WIDTH  (RASTER_MAX_WIDTH),
        .RASTER_MAX_HEIGHT (RASTER_MAX_HEIGHT)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .in_valid      (in_valid),
        .op            (op),
        .point_x       (point_x),
        .point_y       (point_y),
        .pixel_in      (pixel_in),
        .bounds_left   (bounds_left_reg),
        .bounds_top    (bounds_top_reg),
        .bounds_width  (bounds_width_reg),
        .bounds_height (bounds_height_reg),
        .raster_width  (raster_width_reg),
        .raster_height (raster_height_reg),
        .out_stall     (out_stall),
        .out_valid     (out_valid),
        .preview_valid (preview_valid),
        .pixel_out     (pixel_out),
        .window_x      (window_x),
        .window_y      (window_y),
        .last          (last)
    );

endmodule : magnifier_window_sampler_unit

`default_nettype wire

// ----- dv/tb_magnifier_window_sampler_unit.sv -----
// Self-checking testbench for the magnifier window sampler: raster loads, window queries, APB setup.
`timescale 1ns / 100ps

module tb_magnifier_window_sampler_unit;
    import mws_pkg::*;

    localparam int PREVIEW_SIZE  = 7;
    localparam int WINDOW_RADIUS = PREVIEW_SIZE / 2;
    localparam int RASTER_COLS   = 256;
    localparam int RASTER_ROWS   = 256;
    localparam int CYCLE_LIMIT   = 2000000;
    localparam int SETTLE_CYCLES = 32;
    localparam int ITEM_COUNT    = 420;

    typedef struct {
        logic                      op;
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic [PIX_W-1:0]          pix;
    } sample_req_t;

    typedef struct {
        logic             preview_valid;
        logic [PIX_W-1:0] pixel;
        logic [WIN_W-1:0] wx;
        logic [WIN_W-1:0] wy;
        logic             final_beat;
    } window_beat_t;

    logic clk;
    logic rst_n = 1'b0;

    logic               psel    = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite  = 1'b0;
    logic [PADDR_W-1:0] paddr   = '0;
    logic [PDATA_W-1:0] pwdata  = '0;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    logic                      in_valid = 1'b0;
    logic                      in_stall;
    logic                      op       = OP_LOAD;
    logic signed [COORD_W-1:0] point_x  = '0;
    logic signed [COORD_W-1:0] point_y  = '0;
    logic [PIX_W-1:0]          pixel_in = '0;

    logic             out_valid;
    logic             out_stall = 1'b0;
    logic             preview_valid;
    logic [PIX_W-1:0] pixel_out;
    logic [WIN_W-1:0] window_x;
    logic [WIN_W-1:0] window_y;
    logic             last;

    magnifier_window_sampler_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .op           (op),
        .point_x      (point_x),
        .point_y      (point_y),
        .pixel_in     (pixel_in),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .preview_valid(preview_valid),
        .pixel_out    (pixel_out),
        .window_x     (window_x),
        .window_y     (window_y),
        .last         (last)
    );

    // Shadow of the programmed window setup; raster extents are kept saturated.
    int cur_left;
    int cur_top;
    int cur_bw;
    int cur_bh;
    int cur_rw;
    int cur_rh;

    logic [PIX_W-1:0] pixel_shadow [0:RASTER_COLS*RASTER_ROWS-1];
    bit               pixel_loaded [0:RASTER_COLS*RASTER_ROWS-1];

    sample_req_t  pending_reqs[$];
    window_beat_t expected_beats[$];
    sample_req_t  cur_req;
    bit           req_taken;

    int issued_count;
    int accepted_count;
    int query_count;
    int load_count;
    int window_count;
    int empty_count;
    int beats_checked;
    int config_count;
    int fail_count;
    int cycle_count;
    int idle_pct;
    int in_gap;
    int stall_left;
    int random_base;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic int clamp_int(int v, int lo, int hi);
        if (v < lo)
            return lo;
        if (v > hi)
            return hi;
        return v;
    endfunction

    // Center-aligned nearest-neighbour scaling of one axis onto the raster.
    function automatic int map_axis(int phys, int start, int extent, int rext);
        longint off;
        longint q;
        off = longint'(phys - start);
        if (off < 0)
            off = 0;
        if (off > longint'(extent) - 1)
            off = longint'(extent) - 1;
        q = ((2 * off + 1) * longint'(rext)) / (2 * longint'(extent));
        if (q > longint'(rext) - 1)
            q = longint'(rext) - 1;
        return int'(q);
    endfunction

    function automatic bit window_open(int px, int py);
        int right;
        int bottom;
        right  = cur_left + cur_bw - 1;
        bottom = cur_top + cur_bh - 1;
        return cur_rw != 0 && cur_rh != 0 && cur_bw != 0 && cur_bh != 0 &&
               px >= cur_left && px <= right && py >= cur_top && py <= bottom;
    endfunction

    function automatic int window_addr(int px, int py, int row, int col);
        int phx;
        int phy;
        int rx;
        int ry;
        phy = clamp_int(py + row - WINDOW_RADIUS, cur_top, cur_top + cur_bh - 1);
        phx = clamp_int(px + col - WINDOW_RADIUS, cur_left, cur_left + cur_bw - 1);
        ry  = map_axis(phy, cur_top, cur_bh, cur_rh);
        rx  = map_axis(phx, cur_left, cur_bw, cur_rw);
        return ry * RASTER_COLS + rx;
    endfunction

    task automatic predict_request(input sample_req_t r);
        window_beat_t b;
        int           px;
        int           py;
        px = int'(r.x);
        py = int'(r.y);
        if (r.op == OP_LOAD)
        begin
            load_count++;
            if (px >= 0 && px < RASTER_COLS && py >= 0 && py < RASTER_ROWS)
                pixel_shadow[py * RASTER_COLS + px] = r.pix;
        end
        else if (!window_open(px, py))
        begin
            query_count++;
            empty_count++;
            b.preview_valid = 1'b0;
            b.pixel         = '0;
            b.wx            = '0;
            b.wy            = '0;
            b.final_beat    = 1'b1;
            expected_beats.push_back(b);
        end
        else
        begin
            query_count++;
            window_count++;
            for (int row = 0; row < PREVIEW_SIZE; row++)
            begin
                for (int col = 0; col < PREVIEW_SIZE; col++)
                begin
                    b.preview_valid = 1'b1;
                    b.pixel         = pixel_shadow[window_addr(px, py, row, col)];
                    b.wx            = col[WIN_W-1:0];
                    b.wy            = row[WIN_W-1:0];
                    b.final_beat    = (row == PREVIEW_SIZE - 1) && (col == PREVIEW_SIZE - 1);
                    expected_beats.push_back(b);
                end
            end
        end
    endtask

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (got !== want)
        begin
            fail_count++;
            $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
        end
    endtask

    // Input side: a beat moves on a rising edge with valid high and stall low.
    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
        begin
            predict_request(cur_req);
            accepted_count++;
            req_taken = 1'b1;
        end
    end

    always @(negedge clk)
    begin
        if (rst_n && (!in_valid || req_taken))
        begin
            if (req_taken && idle_pct > 0 && $urandom_range(0, 99) < idle_pct)
                in_gap = $urandom_range(1, 8);
            req_taken = 1'b0;
            if (in_gap > 0)
            begin
                in_gap--;
                in_valid <= 1'b0;
            end
            else if (pending_reqs.size() > 0)
            begin
                cur_req = pending_reqs.pop_front();
                op       <= cur_req.op;
                point_x  <= cur_req.x;
                point_y  <= cur_req.y;
                pixel_in <= cur_req.pix;
                in_valid <= 1'b1;
            end
            else
                in_valid <= 1'b0;
        end
    end

    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left--;
            out_stall <= 1'b1;
        end
        else if (rst_n && idle_pct > 0 && $urandom_range(0, 99) < idle_pct)
        begin
            stall_left = $urandom_range(1, 8) - 1;
            out_stall <= 1'b1;
        end
        else
            out_stall <= 1'b0;
    end

    always @(posedge clk)
    begin : result_check
        window_beat_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_beats.size() == 0)
            begin
                fail_count++;
                $display("%0t: unexpected result beat: expected none, actual pixel %h",
                         $time, pixel_out);
            end
            else
            begin
                want = expected_beats.pop_front();
                beats_checked++;
                compare_field("preview_valid", 32'(want.preview_valid), 32'(preview_valid));
                compare_field("pixel_out", want.pixel, pixel_out);
                compare_field("window_x", 32'(want.wx), 32'(window_x));
                compare_field("window_y", 32'(want.wy), 32'(window_y));
                compare_field("last", 32'(want.final_beat), 32'(last));
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: timeout with %0d beats still expected", $time, expected_beats.size());
            $display("magnifier_window_sampler_unit regression: fail");
            $finish;
        end
    end

    task automatic wait_drained();
        do
            @(negedge clk);
        while (accepted_count != issued_count || expected_beats.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic apb_write(input logic [2:0] idx, input logic [PDATA_W-1:0] data);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_window_config(int left, int top, int bw, int bh, int rw, int rh);
        wait_drained();
        apb_write(REG_BOUNDS_LEFT, {16'h0, left[15:0]});
        apb_write(REG_BOUNDS_TOP, {16'h0, top[15:0]});
        apb_write(REG_BOUNDS_WIDTH, {16'h0, bw[15:0]});
        apb_write(REG_BOUNDS_HEIGHT, {16'h0, bh[15:0]});
        apb_write(REG_RASTER_WIDTH, {23'h0, rw[8:0]});
        apb_write(REG_RASTER_HEIGHT, {23'h0, rh[8:0]});
        cur_left = left;
        cur_top  = top;
        cur_bw   = bw;
        cur_bh   = bh;
        cur_rw   = (rw > RASTER_COLS) ? RASTER_COLS : rw;
        cur_rh   = (rh > RASTER_ROWS) ? RASTER_ROWS : rh;
        config_count++;
    endtask

    task automatic queue_load(int x, int y, logic [PIX_W-1:0] pix);
        sample_req_t r;
        int          lx;
        int          ly;
        r.op  = OP_LOAD;
        r.x   = x[15:0];
        r.y   = y[15:0];
        r.pix = pix;
        lx    = int'(r.x);
        ly    = int'(r.y);
        if (lx >= 0 && lx < RASTER_COLS && ly >= 0 && ly < RASTER_ROWS)
            pixel_loaded[ly * RASTER_COLS + lx] = 1'b1;
        pending_reqs.push_back(r);
        issued_count++;
    endtask

    // A window may only touch loaded pixels, so any gap is filled by loads first.
    task automatic queue_query(int px, int py);
        sample_req_t r;
        int          qx;
        int          qy;
        int          addr;
        r.op  = OP_QUERY;
        r.x   = px[15:0];
        r.y   = py[15:0];
        r.pix = $urandom;
        qx    = int'(r.x);
        qy    = int'(r.y);
        if (window_open(qx, qy))
        begin
            for (int row = 0; row < PREVIEW_SIZE; row++)
            begin
                for (int col = 0; col < PREVIEW_SIZE; col++)
                begin
                    addr = window_addr(qx, qy, row, col);
                    if (!pixel_loaded[addr])
                        queue_load(addr % RASTER_COLS, addr / RASTER_COLS, $urandom);
                end
            end
        end
        pending_reqs.push_back(r);
        issued_count++;
    endtask

    function automatic int rand_coord();
        logic signed [15:0] v;
        v = 16'($urandom);
        return int'(v);
    endfunction

    function automatic int pick_origin();
        case ($urandom_range(0, 3))
            0: return $urandom_range(0, 40) - 20;
            1: return $urandom_range(0, 1) ? 32767 - $urandom_range(0, 10)
                                           : -32768 + $urandom_range(0, 10);
            default: return rand_coord();
        endcase
    endfunction

    function automatic int pick_extent();
        case ($urandom_range(0, 15))
            0: return 0;
            1, 2, 3, 4, 5, 6: return $urandom_range(1, 16);
            7, 8, 9, 10, 11: return $urandom_range(1, 400);
            12, 13: return $urandom_range(1, 65535);
            default: return 65535;
        endcase
    endfunction

    function automatic int pick_raster();
        case ($urandom_range(0, 15))
            0: return 0;
            1, 2, 3, 4, 5, 6: return $urandom_range(1, 16);
            7, 8, 9, 10: return $urandom_range(1, 256);
            11, 12: return 256;
            default: return $urandom_range(257, 511);
        endcase
    endfunction

    function automatic int point_within(int origin, int extent);
        int off;
        case ($urandom_range(0, 3))
            0: off = 0;
            1: off = extent - 1;
            default: off = $urandom_range(0, extent - 1);
        endcase
        return (origin + off > 32767) ? 32767 : origin + off;
    endfunction

    function automatic int near_edge(int origin, int extent);
        case ($urandom_range(0, 3))
            0: return origin - 1;
            1: return origin;
            2: return origin + extent - 1;
            default: return origin + extent;
        endcase
    endfunction

    // Fill loads count toward the total, so a phase stops at an overall item mark.
    task automatic run_random_phase(int stop_at);
        int sel;
        while (issued_count < stop_at)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 65 && cur_bw > 0 && cur_bh > 0)
                queue_query(point_within(cur_left, cur_bw), point_within(cur_top, cur_bh));
            else if (sel < 75)
                queue_query(near_edge(cur_left, cur_bw), near_edge(cur_top, cur_bh));
            else if (sel < 85)
                queue_query(rand_coord(), rand_coord());
            else if (sel < 95)
                queue_load($urandom_range(0, (cur_rw > 0) ? cur_rw - 1 : RASTER_COLS - 1),
                           $urandom_range(0, (cur_rh > 0) ? cur_rh - 1 : RASTER_ROWS - 1),
                           $urandom);
            else
                queue_load(rand_coord(), rand_coord(), $urandom);
        end
    endtask

    initial
    begin
        idle_pct = 30;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Reset setup: no raster and no bounds, so any query is an empty preview.
        queue_query(0, 0);
        queue_load(-1, 5, $urandom);
        queue_load(RASTER_COLS, 0, $urandom);
        queue_load(0, -32768, $urandom);
        queue_load(RASTER_COLS - 1, RASTER_ROWS - 1, 32'hFFFF_FFFF);
        queue_load(0, 0, 32'h0000_0000);

        // Widest bounds; the bottom-right corner lies one past the bounds.
        set_window_config(-32768, -32768, 65535, 65535, 256, 256);
        queue_query(-32768, -32768);
        queue_query(32766, 32766);
        queue_query(32767, 0);
        queue_query(0, 0);

        // One-pixel bounds and raster at the top of the coordinate range.
        set_window_config(32767, 32767, 1, 1, 1, 1);
        queue_query(32767, 32767);
        queue_query(32766, 32767);

        // Bounds running past the 16-bit range, oversized raster registers.
        set_window_config(32767, -5, 65535, 9, 511, 300);
        queue_query(32767, -5);
        queue_query(32767, 3);

        set_window_config(-3, 5, 3, 2, 256, 1);
        queue_query(-3, 5);
        queue_query(-1, 6);
        queue_query(-4, 5);
        queue_query(-1, 7);

        set_window_config(10, 10, 20, 20, 0, 8);
        queue_query(15, 15);
        set_window_config(10, 10, 20, 0, 8, 8);
        queue_query(15, 15);

        random_base = issued_count;
        for (int p = 0; p < 8; p++)
        begin
            set_window_config(pick_origin(), pick_origin(), pick_extent(), pick_extent(),
                              pick_raster(), pick_raster());
            case ($urandom_range(0, 2))
                0: idle_pct = 0;
                1: idle_pct = 25;
                default: idle_pct = 50;
            endcase
            if (p == 7)
                idle_pct = 0;
            run_random_phase(random_base + (ITEM_COUNT - random_base) * (p + 1) / 8);
        end

        wait_drained();
        $display("Covered %0d queries (%0d windows, %0d empty) and %0d loads over %0d setups.",
                 query_count, window_count, empty_count, load_count, config_count);
        $display("Checked %0d result beats in %0d cycles.", beats_checked, cycle_count);
        if (fail_count == 0)
            $display("magnifier_window_sampler_unit regression: pass");
        else
            $display("magnifier_window_sampler_unit regression: fail");
        $finish;
    end

endmodule
